// File: rtl/core/clock_seven_segment_scanner_core_macros.svh
// assertion macros shared by the scanner checker
`ifndef CLOCK_SEVEN_SEGMENT_SCANNER_CORE_MACROS_SVH
`define CLOCK_SEVEN_SEGMENT_SCANNER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csss check failed");

// next-cycle implication, disabled during reset
`define CSSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csss check failed");

`endif

// File: rtl/core/csss_pkg.sv
// constants, codes and decode helpers of the seven-segment clock scanner
`timescale 1ns / 1ps
`default_nettype none

package csss_pkg;

    // default timing parameters
    localparam int TICKS_PER_TENTH_DEF   = 40;
    localparam int COLON_HALF_PERIOD_DEF = 200;

    // stream widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int TOD_W      = 11;
    localparam int SEG_W      = 8;
    localparam int ANODE_W    = 4;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // command codes carried in tuser
    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_UPDATE = 1'b1
    } command_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TWELVE_HOUR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOVER    = 1'b1;

    localparam logic [HOLD_W-1:0] HOLDOVER_RESET = 8'd50;

    // time split constants: hour = (tod * 1093) >> 16 is exact below one day
    localparam logic [TOD_W-1:0] MINUTES_PER_DAY = 11'd1440;
    localparam logic [TOD_W-1:0] HOUR_RECIP      = 11'd1093;
    localparam int               HOUR_SHIFT      = 16;

    // segment patterns
    localparam logic [SEG_W-1:0] PATTERN_DASH  = 8'h40;
    localparam logic [SEG_W-1:0] PATTERN_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] POINT_BIT     = 8'h80;

    // digit positions
    localparam logic [1:0] DIGIT_HOUR_TENS = 2'd0;
    localparam logic [1:0] DIGIT_HOUR_ONES = 2'd1;
    localparam logic [1:0] DIGIT_MIN_TENS  = 2'd2;
    localparam logic [1:0] DIGIT_MIN_ONES  = 2'd3;

    // result fields before packing
    typedef struct packed {
        logic             tenth_pulse;
        logic             colon;
        logic [ANODE_W-1:0] anode_drive;
        logic [SEG_W-1:0] segments;
    } result_t;

    // active-low anode select per digit position
    function automatic logic [ANODE_W-1:0] anode_map(input logic [1:0] digit);
        logic [ANODE_W-1:0] code;
        case (digit)
            DIGIT_HOUR_TENS: code = 4'hD;
            DIGIT_HOUR_ONES: code = 4'hE;
            DIGIT_MIN_TENS:  code = 4'h7;
            DIGIT_MIN_ONES:  code = 4'hB;
            default:         code = 4'hF;
        endcase
        return code;
    endfunction

    // decimal digit to segments a..g
    function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] value);
        logic [SEG_W-1:0] pat;
        case (value)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h67;
            default: pat = PATTERN_BLANK;
        endcase
        return pat;
    endfunction

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] value);
        logic [2:0] tens;
        if (value >= 6'd60)
            tens = 3'd6;
        else if (value >= 6'd50)
            tens = 3'd5;
        else if (value >= 6'd40)
            tens = 3'd4;
        else if (value >= 6'd30)
            tens = 3'd3;
        else if (value >= 6'd20)
            tens = 3'd2;
        else if (value >= 6'd10)
            tens = 3'd1;
        else
            tens = 3'd0;
        return tens;
    endfunction

    // ones digit given the tens digit
    function automatic logic [3:0] ones_of(input logic [5:0] value, input logic [2:0] tens);
        logic [5:0] tens_x10;
        logic [5:0] rest;
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        rest     = value - tens_x10;
        return rest[3:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/clock_seven_segment_scanner_core.sv
// four-digit multiplexed seven-segment clock scanner, top level
//
//  channel  | signals                         | content
//  ---------+---------------------------------+-----------------------------------
//  s_axis   | tvalid tready tdata tuser       | tuser: command; tdata: time_of_day
//  m_axis   | tvalid tready tdata             | segments, anode_drive, colon, tenth
//  cfg      | valid ready index data          | twelve_hour_mode, holdover_limit
//
// one transaction per cycle: a tick or update is taken from the input side and applied
// to the state at the accepting edge; a tick's result is offered from the next cycle.
// s_axis_tready is high while the output register is empty or being drained, so a
// result held by a stall blocks the input side. Updates produce no result. cfg_ready
// is always high. rst_n resets all but the payload; holdover starts expired (dashes).
`timescale 1ns / 1ps
`default_nettype none

module clock_seven_segment_scanner_core #(
    parameter int TICKS_PER_TENTH   = csss_pkg::TICKS_PER_TENTH_DEF,
    parameter int COLON_HALF_PERIOD = csss_pkg::COLON_HALF_PERIOD_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [10:0] time_of_day, [15:11] zero
    input  wire [csss_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] command
    input  wire [0:0]                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [7:0] segments, [11:8] anode_drive, [12] colon, [13] tenth_pulse, [15:14] zero
    output logic [csss_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [csss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [csss_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import csss_pkg::*;

    localparam int SCAN_W  = (TICKS_PER_TENTH > 4) ? $clog2(TICKS_PER_TENTH) : 2;
    localparam int COLON_W = $clog2(COLON_HALF_PERIOD + 1);
    localparam logic [SCAN_W-1:0]  SCAN_LAST  = SCAN_W'(TICKS_PER_TENTH - 1);
    localparam logic [COLON_W-1:0] COLON_LAST = COLON_W'(COLON_HALF_PERIOD);

    // configuration registers
    logic               twelve_hour_reg;
    logic [HOLD_W-1:0]  holdover_limit_reg;

    // display state
    logic [HOUR_W-1:0]   hour_reg,         hour_next;
    logic [MINUTE_W-1:0] minute_reg,       minute_next;
    logic [SCAN_W-1:0]   scan_count_reg,   scan_count_next;
    logic [COLON_W-1:0]  colon_count_reg,  colon_count_next;
    logic                colon_level_reg,  colon_level_next;
    logic [HOLD_W-1:0]   holdover_reg,     holdover_next;

    // output register
    logic                out_valid_reg,    out_valid_next;
    result_t             out_data_reg,     out_data_next;

    logic                in_accept;
    logic                is_tick;
    logic                is_update;

    // time split signals
    logic [TOD_W-1:0]    tod_in;
    logic [TOD_W-1:0]    tod_wrap;
    logic [2*TOD_W-1:0]  hour_prod;
    logic [HOUR_W-1:0]   hour_split;
    logic [TOD_W-1:0]    hour_x60;
    logic [TOD_W-1:0]    minute_full;

    // digit decode signals
    logic [1:0]          digit;
    logic [HOUR_W-1:0]   hour_shown;
    logic [2:0]          hour_tens;
    logic [3:0]          hour_ones;
    logic [2:0]          min_tens;
    logic [3:0]          min_ones;
    logic [SEG_W-1:0]    time_seg;
    logic [SEG_W-1:0]    seg_out;
    logic                pm_point;
    logic                tick_pulse;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_tick       = in_accept && (command_t'(s_axis_tuser[0]) == CMD_TICK);
    assign is_update     = in_accept && (command_t'(s_axis_tuser[0]) == CMD_UPDATE);

    // time split: wrap past midnight, hour by reciprocal, minute as remainder
    assign tod_in      = s_axis_tdata[TOD_W-1:0];
    assign tod_wrap    = (tod_in >= MINUTES_PER_DAY) ? (tod_in - MINUTES_PER_DAY) : tod_in;
    assign hour_prod   = tod_wrap * HOUR_RECIP;
    assign hour_split  = hour_prod[HOUR_SHIFT +: HOUR_W];
    assign hour_x60    = {hour_split, 6'b000000} - {4'b0000, hour_split, 2'b00};
    assign minute_full = tod_wrap - hour_x60;

    // 12-hour adjustment and digit characters
    always_comb
    begin
        hour_shown = hour_reg;
        if (twelve_hour_reg)
        begin
            if (hour_reg == '0)
                hour_shown = 5'd12;
            else if (hour_reg > 5'd12)
                hour_shown = hour_reg - 5'd12;
        end
        hour_tens = tens_of({1'b0, hour_shown});
        hour_ones = ones_of({1'b0, hour_shown}, hour_tens);
        min_tens  = tens_of(minute_reg);
        min_ones  = ones_of(minute_reg, min_tens);
    end

    // segment pattern of the current digit
    assign digit = scan_count_reg[1:0];

    always_comb
    begin
        case (digit)
            DIGIT_HOUR_TENS:
                time_seg = (twelve_hour_reg && hour_tens == 3'd0) ? PATTERN_BLANK
                                                                  : digit_pattern({1'b0, hour_tens});
            DIGIT_HOUR_ONES: time_seg = digit_pattern(hour_ones);
            DIGIT_MIN_TENS:  time_seg = digit_pattern({1'b0, min_tens});
            DIGIT_MIN_ONES:  time_seg = digit_pattern(min_ones);
            default:         time_seg = PATTERN_BLANK;
        endcase
    end

    assign pm_point = twelve_hour_reg && (hour_reg >= 5'd12) && (digit == DIGIT_MIN_ONES);
    assign seg_out  = ((holdover_reg == '0) ? PATTERN_DASH : time_seg)
                      | (pm_point ? POINT_BIT : '0);
    assign tick_pulse = (scan_count_reg == SCAN_LAST);

    // next state for ticks and updates
    always_comb
    begin
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        scan_count_next  = scan_count_reg;
        colon_count_next = colon_count_reg;
        colon_level_next = colon_level_reg;
        holdover_next    = holdover_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;

        if (is_update)
        begin
            hour_next     = hour_split;
            minute_next   = minute_full[MINUTE_W-1:0];
            holdover_next = holdover_limit_reg;
        end

        if (is_tick)
        begin
            // colon half-period counter
            if (colon_count_reg == COLON_LAST)
            begin
                colon_count_next = COLON_W'(1);
                colon_level_next = !colon_level_reg;
            end
            else
            begin
                colon_count_next = colon_count_reg + 1'b1;
            end

            // scan counter and tenth countdown
            if (tick_pulse)
            begin
                scan_count_next = '0;
                if (holdover_reg != '0)
                    holdover_next = holdover_reg - 1'b1;
            end
            else
            begin
                scan_count_next = scan_count_reg + 1'b1;
            end

            out_valid_next            = 1'b1;
            out_data_next.segments    = seg_out;
            out_data_next.anode_drive = anode_map(digit);
            out_data_next.colon       = colon_level_next;
            out_data_next.tenth_pulse = tick_pulse;
        end
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twelve_hour_reg    <= 1'b0;
            holdover_limit_reg <= HOLDOVER_RESET;
            hour_reg           <= '0;
            minute_reg         <= '0;
            scan_count_reg     <= '0;
            colon_count_reg    <= '0;
            colon_level_reg    <= 1'b0;
            holdover_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TWELVE_HOUR)
                    twelve_hour_reg <= cfg_data[0];
                else if (cfg_index == REG_HOLDOVER)
                    holdover_limit_reg <= cfg_data;
            end
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            scan_count_reg  <= scan_count_next;
            colon_count_reg <= colon_count_next;
            colon_level_reg <= colon_level_next;
            holdover_reg    <= holdover_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule

`default_nettype wire

// File: rtl/core/csss_checker.sv
// port-level checker for the seven-segment clock scanner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "clock_seven_segment_scanner_core_macros.svh"

module csss_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tready,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [15:0]  m_axis_tdata,
    input  wire         cfg_valid,
    input  wire         cfg_ready
);
    logic stalled;

    assign stalled = m_axis_tvalid && !m_axis_tready;

    // a stalled result stays offered with the same payload
    `CSSS_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata))

    // an empty output register never blocks the input side
    `CSSS_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // exactly one digit is driven low per result
    `CSSS_ASSERT_NOW(a_one_anode, m_axis_tvalid, $onehot(~m_axis_tdata[11:8]))

    // the decimal point appears only on the last digit
    `CSSS_ASSERT_NOW(a_point_digit3, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[11:8] == 4'hB)

    // register writes are never held off
    `CSSS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind clock_seven_segment_scanner_core csss_checker u_csss_checker (.*);

`default_nettype wire

// File: dv/clock_seven_segment_scanner_checker.sv
// checker for the seven-segment clock scanner: predicts each tick result and compares it
`timescale 1ns / 1ps

module clock_seven_segment_scanner_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    input  wire                                 s_axis_tready,
    // [10:0] time_of_day, [15:11] zero
    input  wire [csss_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] command
    input  wire [0:0]                           s_axis_tuser,
    input  wire                                 m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [7:0] segments, [11:8] anode_drive, [12] colon, [13] tenth_pulse, [15:14] zero
    input  wire [csss_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire                                 cfg_valid,
    input  wire                                 cfg_ready,
    input  wire [csss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [csss_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  pending,
    output int                                  failures
);

    localparam int TICKS_PER_TENTH   = csss_pkg::TICKS_PER_TENTH_DEF;
    localparam int COLON_HALF_PERIOD = csss_pkg::COLON_HALF_PERIOD_DEF;
    localparam int MINUTES_PER_HOUR  = 60;
    localparam int MINUTES_PER_DAY   = 1440;

    // register copies
    logic                           twelve_mode;
    logic [csss_pkg::HOLD_W-1:0]    hold_limit;

    // display state
    logic [csss_pkg::HOUR_W-1:0]    hour_q;
    logic [csss_pkg::MINUTE_W-1:0]  minute_q;
    logic [5:0]                     scan_q;
    logic [7:0]                     colon_cnt;
    logic                           colon_lvl;
    logic [csss_pkg::HOLD_W-1:0]    hold_q;

    // tick results still to come out, oldest first
    csss_pkg::result_t scan_results_due[$];

    // seven-segment font, segments a..g
    function automatic logic [csss_pkg::SEG_W-1:0] seg_font(input int value);
        logic [csss_pkg::SEG_W-1:0] pat;
        case (value)
            0:       pat = 8'h3F;
            1:       pat = 8'h06;
            2:       pat = 8'h5B;
            3:       pat = 8'h4F;
            4:       pat = 8'h66;
            5:       pat = 8'h6D;
            6:       pat = 8'h7D;
            7:       pat = 8'h07;
            8:       pat = 8'h7F;
            default: pat = 8'h67;
        endcase
        return pat;
    endfunction

    task automatic report(input string field, input int want, input int got);
        if (want != got)
        begin
            failures++;
            $display("%0t mismatch %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // watch all three channels, predict and compare
    always @(posedge clk or negedge rst_n)
    begin : predict_and_check
        int                          tod;
        int                          hr;
        int                          next_val;
        logic [1:0]                  digit;
        logic                        pulse;
        logic [csss_pkg::SEG_W-1:0]  seg;
        csss_pkg::result_t           want;
        csss_pkg::result_t           got;
        if (!rst_n)
        begin
            twelve_mode = 1'b0;
            hold_limit  = csss_pkg::HOLDOVER_RESET;
            hour_q      = '0;
            minute_q    = '0;
            scan_q      = '0;
            colon_cnt   = '0;
            colon_lvl   = 1'b0;
            hold_q      = '0;
            scan_results_due.delete();
            failures    = 0;
        end
        else
        begin
            // output transaction against the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[13:0];
                if (scan_results_due.size() == 0)
                begin
                    failures++;
                    $display("%0t unexpected result expected none actual %0h", $time, got);
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    report("segments", want.segments, got.segments);
                    report("anode_drive", want.anode_drive, got.anode_drive);
                    report("colon", want.colon, got.colon);
                    report("tenth_pulse", want.tenth_pulse, got.tenth_pulse);
                end
            end

            // register writes only store the value
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == csss_pkg::REG_TWELVE_HOUR)
                    twelve_mode = cfg_data[0];
                else if (cfg_index == csss_pkg::REG_HOLDOVER)
                    hold_limit = cfg_data;
            end

            // input transaction
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == csss_pkg::CMD_UPDATE)
                begin
                    // times past the day wrap into the next day
                    tod = int'(s_axis_tdata[csss_pkg::TOD_W-1:0]);
                    if (tod >= MINUTES_PER_DAY)
                        tod -= MINUTES_PER_DAY;
                    hour_q   = csss_pkg::HOUR_W'(tod / MINUTES_PER_HOUR);
                    minute_q = csss_pkg::MINUTE_W'(tod % MINUTES_PER_HOUR);
                    hold_q   = hold_limit;
                end
                else
                begin
                    digit = scan_q[1:0];
                    hr    = int'(hour_q);
                    if (twelve_mode)
                    begin
                        if (hr == 0)
                            hr = 12;
                        else if (hr > 12)
                            hr -= 12;
                    end

                    // digit character, dashes once holdover ran out
                    if (hold_q == 0)
                        seg = csss_pkg::PATTERN_DASH;
                    else
                    begin
                        case (digit)
                            csss_pkg::DIGIT_HOUR_TENS:
                                seg = (twelve_mode && hr < 10) ? csss_pkg::PATTERN_BLANK
                                                               : seg_font(hr / 10);
                            csss_pkg::DIGIT_HOUR_ONES: seg = seg_font(hr % 10);
                            csss_pkg::DIGIT_MIN_TENS:  seg = seg_font(int'(minute_q) / 10);
                            default:                   seg = seg_font(int'(minute_q) % 10);
                        endcase
                    end

                    // pm point on the last digit, also over dashes
                    if (twelve_mode && hour_q >= 12 && digit == csss_pkg::DIGIT_MIN_ONES)
                        seg = seg | csss_pkg::POINT_BIT;

                    // colon toggle
                    next_val = int'(colon_cnt) + 1;
                    if (next_val > COLON_HALF_PERIOD)
                    begin
                        next_val -= COLON_HALF_PERIOD;
                        colon_lvl = ~colon_lvl;
                    end
                    colon_cnt = 8'(next_val);

                    // tenth pulse and holdover countdown, held at zero
                    pulse    = 1'b0;
                    next_val = int'(scan_q) + 1;
                    if (next_val >= TICKS_PER_TENTH)
                    begin
                        next_val -= TICKS_PER_TENTH;
                        pulse = 1'b1;
                        if (hold_q != 0)
                            hold_q = hold_q - 1'b1;
                    end
                    scan_q = 6'(next_val);

                    want.segments = seg;
                    case (digit)
                        csss_pkg::DIGIT_HOUR_TENS: want.anode_drive = 4'hD;
                        csss_pkg::DIGIT_HOUR_ONES: want.anode_drive = 4'hE;
                        csss_pkg::DIGIT_MIN_TENS:  want.anode_drive = 4'h7;
                        default:                   want.anode_drive = 4'hB;
                    endcase
                    want.colon       = colon_lvl;
                    want.tenth_pulse = pulse;
                    scan_results_due.push_back(want);
                end
            end
        end
        pending = scan_results_due.size();
    end

endmodule

// File: dv/tb_clock_seven_segment_scanner_core.sv
// testbench top for the seven-segment clock scanner: stimulus, pacing and verdict
`timescale 1ns / 1ps

module tb_clock_seven_segment_scanner_core;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 1500;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [csss_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
    logic [0:0]                          s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [csss_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [csss_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [csss_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    int pending;
    int failures;
    int cycle_count = 0;
    int rx_cycle;
    int hold_left;
    logic hold_done;
    int burst_left = 0;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    clock_seven_segment_scanner_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    clock_seven_segment_scanner_checker display_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .failures      (failures)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver pacing: rotating stall density plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_cycle      <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && rx_cycle > HOLD_OFF_AFTER && s_axis_tvalid)
            begin
                hold_left     <= HOLD_OFF_CYCLES;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 256) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(3) != 0);
                    2:       m_axis_tready <= ($urandom_range(3) == 0);
                    default: m_axis_tready <= $urandom_range(1);
                endcase
            end
        end
    end

    // offer one item and hold it until the transaction completes
    task automatic send_item(input csss_pkg::command_t cmd, input logic [10:0] tod);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, tod};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // burst bookkeeping, random gap between bursts
    task automatic pace(input int gap_max);
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(12);
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // drain every expected result, then let a trailing update settle
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic twelve, input logic [7:0] limit);
        logic [7:0] mode_word;
        settle();
        mode_word    = 8'($urandom);
        mode_word[0] = twelve;
        cfg_valid <= 1'b1;
        cfg_index <= csss_pkg::REG_TWELVE_HOUR;
        cfg_data  <= mode_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b1;
        cfg_index <= csss_pkg::REG_HOLDOVER;
        cfg_data  <= limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one setting, then random ticks and updates
    task automatic run_phase(input logic twelve, input logic [7:0] limit, input int count,
                             input int gap_max, input int update_pct);
        int k;
        logic [10:0] tod;
        configure(twelve, limit);
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                0: tod = 11'($urandom_range(2047, 1440));
                1:
                begin
                    case ($urandom_range(7))
                        0:       tod = 11'd0;
                        1:       tod = 11'd719;
                        2:       tod = 11'd720;
                        3:       tod = 11'd779;
                        4:       tod = 11'd780;
                        5:       tod = 11'd1439;
                        6:       tod = 11'd1440;
                        default: tod = 11'd2047;
                    endcase
                end
                default: tod = 11'($urandom_range(1439));
            endcase
            if ($urandom_range(99) < update_pct)
                send_item(csss_pkg::CMD_UPDATE, tod);
            else
                send_item(csss_pkg::CMD_TICK, tod);
            pace(gap_max);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // dashes out of reset on all four digits
        repeat (4) send_item(csss_pkg::CMD_TICK, 11'd0);
        // midnight, last minute of the day, time past the day
        send_item(csss_pkg::CMD_UPDATE, 11'd0);
        repeat (4) send_item(csss_pkg::CMD_TICK, 11'h7FF);
        send_item(csss_pkg::CMD_UPDATE, 11'd1439);
        repeat (4) send_item(csss_pkg::CMD_TICK, 11'd0);
        send_item(csss_pkg::CMD_UPDATE, 11'd2047);
        send_item(csss_pkg::CMD_TICK, 11'h7FF);

        // zero holdover: dashes at once, pm point still on the last digit
        configure(1'b1, 8'd0);
        send_item(csss_pkg::CMD_UPDATE, 11'd780);
        repeat (4) send_item(csss_pkg::CMD_TICK, 11'h555);

        // random phases across settings, extremes included
        run_phase(1'b0, 8'd1,   200, 3, 5);
        run_phase(1'b1, 8'd255, 200, 0, 20);
        run_phase(1'b1, 8'd2,   250, 6, 4);
        run_phase(1'b0, 8'd0,   150, 2, 15);
        run_phase(1'b1, 8'd50,  300, 4, 10);
        run_phase(1'b0, 8'd255, 150, 8, 25);
        run_phase(1'b1, 8'd1,   150, 3, 3);

        settle();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/csss_pkg.sv
rtl/core/clock_seven_segment_scanner_core.sv
rtl/core/csss_checker.sv
dv/clock_seven_segment_scanner_checker.sv
dv/tb_clock_seven_segment_scanner_core.sv
